FILE: design/mlpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpc_pkg
// shared types and constants of the mapper-aware page cache tag store
// ----------------------------------------------------------------------------
package mlpc_pkg;

   typedef enum logic [1:0] {
      OP_WRITE     = 2'd0,
      OP_READ      = 2'd1,
      OP_FILL_FAIL = 2'd2,
      OP_INVAL_ALL = 2'd3
   } op_type;

   localparam logic [2:0] PROF_NONE      = 3'd0;
   localparam logic [2:0] PROF_LINEAR    = 3'd1;
   localparam logic [2:0] PROF_KONAMI    = 3'd2;
   localparam logic [2:0] PROF_SCC       = 3'd3;
   localparam logic [2:0] PROF_ASCII8    = 3'd4;
   localparam logic [2:0] PROF_ASCII16   = 3'd5;
   localparam logic [2:0] PROF_LAST      = PROF_ASCII16;

   localparam logic [13:0] PAGE_SPAN     = 14'h2000;
   localparam logic [13:0] SPLIT_SPAN    = 14'h1800;
   localparam int          TAG_W         = 39;
   localparam int          STAMP_W       = 64;

   typedef struct packed {
      logic load_item;
      logic scan_start;
      logic scan_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic needs_scan;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

FILE: design/mlpc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mlpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/mlpc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpc_datapath
// item decode, bank state, tag and stamp stores, scan accumulators, result
// ----------------------------------------------------------------------------
module mlpc_datapath #(
   parameter int ENTRY_COUNT = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  mlpc_pkg::cmd_type    cmd,
   output mlpc_pkg::status_type status,
   input  logic [1:0]          req_operation,
   input  logic [15:0]         req_address,
   input  logic [7:0]          req_data_byte,
   input  logic [16:0]         req_bytes_left,
   input  logic [7:0]          req_entry_slot,
   input  logic                csr_we,
   input  logic [2:0]          csr_wdata,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_is_direct,
   output logic                rsp_is_hit,
   output logic [7:0]          rsp_slot_index,
   output logic [15:0]         rsp_fill_start,
   output logic [13:0]         rsp_fill_length,
   output logic [13:0]         rsp_segment_count,
   output logic                rsp_flushed
);
   import mlpc_pkg::*;

   localparam int IDX_W  = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam int SLOT_W = (IDX_W > 8) ? IDX_W : 8;

   // latched item
   op_type        op_ff;
   logic [15:0]   addr_ff;
   logic [7:0]    data_ff;
   logic [16:0]   left_ff;
   logic [7:0]    slot_ff;

   logic [2:0]    profile_ff;
   logic [7:0]    bank_ff [4];
   logic [3:0]    known_ff;
   logic [ENTRY_COUNT-1:0] valid_ff;
   logic [STAMP_W-1:0] clock_ff;

   // scan state
   logic [IDX_W-1:0]   scan_idx_ff;
   logic               rd_pend_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               rd_vq_ff;
   logic               found_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic               inv_ff;
   logic [IDX_W-1:0]   inv_idx_ff;
   logic [STAMP_W-1:0] min_stamp_ff;
   logic [IDX_W-1:0]   min_idx_ff;

   logic               rsp_valid_ff;
   logic               is_direct_ff, is_hit_ff, flushed_ff;
   logic [7:0]         slot_out_ff;
   logic [15:0]        fill_start_ff;
   logic [13:0]        fill_len_ff, count_ff;

   // read decode
   logic        split_page, beyond_split, direct_rd, needs_scan;
   logic [13:0] span, room, count;
   logic [15:0] page_start;

   always_comb begin
      page_start   = {addr_ff[15:13], 13'd0};
      split_page   = (profile_ff == PROF_SCC) &&
                     (addr_ff[15:13] == 3'd4 || addr_ff[15:13] == 3'd5);
      beyond_split = addr_ff[12:11] == 2'b11;
      direct_rd    = (profile_ff == PROF_NONE) || (addr_ff < 16'h4000) ||
                     (addr_ff >= 16'hc000) || (split_page && beyond_split);
      span         = (split_page && !beyond_split) ? SPLIT_SPAN : PAGE_SPAN;
      room         = span - {1'b0, addr_ff[12:0]};
      count        = (left_ff < {3'd0, room}) ? left_ff[13:0] : room;
      needs_scan   = (op_ff == OP_READ) && !direct_rd && (count != 14'd0);
   end

   // write decode
   logic        sel_ok, scc_skip;
   logic [1:0]  sel;
   logic [15:0] diff;

   always_comb begin
      sel_ok   = 1'b0;
      sel      = 2'd0;
      diff     = 16'd0;
      scc_skip = 1'b0;
      case (profile_ff)
         PROF_KONAMI: begin
            sel_ok = (addr_ff >= 16'h6000) && (addr_ff < 16'hc000);
            sel    = 2'(addr_ff[15:13] - 3'd2);
         end
         PROF_SCC: begin
            diff     = addr_ff - 16'h5000;
            sel_ok   = (addr_ff >= 16'h5000) && (addr_ff < 16'hb800) &&
                       (addr_ff[12:11] == 2'b10);
            sel      = diff[14:13];
            // scc sound window once bank 2 selects it
            scc_skip = (addr_ff >= 16'h9800) && (addr_ff < 16'ha000) &&
                       known_ff[2] && (bank_ff[2][5:0] == 6'h3f);
         end
         PROF_ASCII8: begin
            diff   = addr_ff - 16'h6000;
            sel_ok = (addr_ff >= 16'h6000) && (addr_ff < 16'h8000);
            sel    = diff[12:11];
         end
         PROF_ASCII16: begin
            diff   = addr_ff - 16'h6000;
            sel_ok = (addr_ff >= 16'h6000) && (addr_ff < 16'h7800) && !addr_ff[11];
            sel    = {1'b0, diff[12]};
         end
         default: begin
            sel_ok = 1'b0;
         end
      endcase
   end

   logic [TAG_W-1:0]   cur_tag, rd_tag;
   logic [STAMP_W-1:0] rd_stamp, stamp_next;
   logic [IDX_W-1:0]   victim, stamp_addr, slot_idx;
   logic [SLOT_W-1:0]  slot_wide, out_wide;
   logic               slot_ok, tag_we, stamp_we, flush, cfg_clear;

   assign cur_tag    = {known_ff, bank_ff[3], bank_ff[2], bank_ff[1], bank_ff[0],
                        addr_ff[15:13]};
   assign victim     = inv_ff ? inv_idx_ff : min_idx_ff;
   assign stamp_addr = found_ff ? hit_idx_ff : victim;
   assign stamp_next = clock_ff + 64'd1;
   assign tag_we     = cmd.commit && needs_scan && !found_ff;
   assign stamp_we   = cmd.commit && needs_scan;
   assign slot_wide  = SLOT_W'(slot_ff);
   assign slot_idx   = slot_wide[IDX_W-1:0];
   assign slot_ok    = 32'(slot_ff) < 32'(ENTRY_COUNT);
   assign out_wide   = SLOT_W'(stamp_addr);
   assign cfg_clear  = csr_we && (csr_wdata <= PROF_LAST);
   assign flush      = cmd.commit && ((op_ff == OP_INVAL_ALL) ||
                       ((op_ff == OP_WRITE) && !scc_skip && !sel_ok));

   mlpc_ram #(.WIDTH(TAG_W), .DEPTH(ENTRY_COUNT), .AW(IDX_W)) u_tag_ram (
      .clock  (clock),
      .wr_en  (tag_we),
      .wr_addr(victim),
      .wr_data(cur_tag),
      .rd_en  (cmd.scan_step),
      .rd_addr(scan_idx_ff),
      .rd_data(rd_tag)
   );

   mlpc_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRY_COUNT), .AW(IDX_W)) u_stamp_ram (
      .clock  (clock),
      .wr_en  (stamp_we),
      .wr_addr(stamp_addr),
      .wr_data(stamp_next),
      .rd_en  (cmd.scan_step),
      .rd_addr(scan_idx_ff),
      .rd_data(rd_stamp)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= op_type'(req_operation);
         addr_ff <= req_address;
         data_ff <= req_data_byte;
         left_ff <= req_bytes_left;
         slot_ff <= req_entry_slot;
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         profile_ff <= PROF_NONE;
         known_ff   <= '0;
         valid_ff   <= '0;
         clock_ff   <= '0;
         for (int j = 0; j < 4; j++) bank_ff[j] <= '0;
      end else if (cfg_clear || flush) begin
         if (cfg_clear) profile_ff <= csr_wdata;
         known_ff <= '0;
         valid_ff <= '0;
         clock_ff <= '0;
         for (int j = 0; j < 4; j++) bank_ff[j] <= '0;
      end else if (cmd.commit) begin
         if (op_ff == OP_WRITE && sel_ok && !scc_skip) begin
            bank_ff[sel]  <= data_ff;
            known_ff[sel] <= 1'b1;
         end
         if (op_ff == OP_FILL_FAIL && slot_ok) valid_ff[slot_idx] <= 1'b0;
         if (needs_scan) begin
            clock_ff <= stamp_next;
            if (!found_ff) valid_ff[victim] <= 1'b1;
         end
      end
   end

   // scan pipeline: address issue, then compare once rd_pend_ff and the registered ram read have loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.scan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_idx_ff <= '0;
         found_ff    <= 1'b0;
         inv_ff      <= 1'b0;
      end else begin
         if (cmd.scan_step) begin
            scan_idx_ff <= scan_idx_ff + IDX_W'(1);
            rd_idx_ff   <= scan_idx_ff;
            rd_vq_ff    <= valid_ff[scan_idx_ff];
         end
         if (rd_pend_ff) begin
            if (rd_vq_ff && rd_tag == cur_tag && !found_ff) begin
               found_ff   <= 1'b1;
               hit_idx_ff <= rd_idx_ff;
            end
            if (!rd_vq_ff && !inv_ff) begin
               inv_ff     <= 1'b1;
               inv_idx_ff <= rd_idx_ff;
            end
            if (rd_vq_ff && !inv_ff &&
                (rd_idx_ff == '0 || rd_stamp < min_stamp_ff)) begin
               min_stamp_ff <= rd_stamp;
               min_idx_ff   <= rd_idx_ff;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         is_direct_ff  <= (op_ff == OP_READ) && direct_rd && (count != 14'd0);
         is_hit_ff     <= needs_scan && found_ff;
         slot_out_ff   <= needs_scan ? out_wide[7:0] : 8'd0;
         fill_start_ff <= (needs_scan && !found_ff) ? page_start : 16'd0;
         fill_len_ff   <= (needs_scan && !found_ff) ? span : 14'd0;
         count_ff      <= (op_ff == OP_READ) ? count : 14'd0;
         flushed_ff    <= flush;
      end
   end

   assign status.needs_scan = needs_scan;
   assign status.scan_last  = scan_idx_ff == IDX_W'(ENTRY_COUNT - 1);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_direct     = is_direct_ff;
   assign rsp_is_hit        = is_hit_ff;
   assign rsp_slot_index    = slot_out_ff;
   assign rsp_fill_start    = fill_start_ff;
   assign rsp_fill_length   = fill_len_ff;
   assign rsp_segment_count = count_ff;
   assign rsp_flushed       = flushed_ff;

endmodule

FILE: design/mlpc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpc_ctrl
// sequencer: take one beat, decode, scan the tag store if needed, commit the result
// ----------------------------------------------------------------------------
module mlpc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mlpc_pkg::status_type status,
   output mlpc_pkg::cmd_type    cmd
);
   import mlpc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECODE = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (status.needs_scan) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            // last compare lands this cycle
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("commit while result register is occupied");

   a_accept_to_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_DECODE)
      else $error("accepted beat not decoded");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && status.scan_last) |=> (state_ff == ST_DRAIN && !cmd.scan_step))
      else $error("scan ran past the last entry");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit && (cmd.scan_step || cmd.scan_start || cmd.load_item)))
      else $error("commit overlaps other work");

endmodule

FILE: design/mapper_aware_lru_page_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapper_aware_lru_page_cache_unit
// tag store of a rom page cache keyed by page and bank mapper state
// ----------------------------------------------------------------------------
// sequence: beats with no tag scan (writes, fill-failed, invalidate, direct and
//   zero-length reads) go through decode and commit; cached reads go through
//   decode, one ram read per entry, drain and commit; commit waits for a free
//   result register. one beat at a time: the next beat is taken the cycle after
//   the result loads
// reset: profile none, bank state, valid bits and use clock cleared at once
module mapper_aware_lru_page_cache_unit #(
   parameter int ENTRY_COUNT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data_byte,
   input  logic [16:0] req_bytes_left,
   input  logic [7:0]  req_entry_slot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_direct,
   output logic        rsp_is_hit,
   output logic [7:0]  rsp_slot_index,
   output logic [15:0] rsp_fill_start,
   output logic [13:0] rsp_fill_length,
   output logic [13:0] rsp_segment_count,
   output logic        rsp_flushed,
   input  logic        csr_we,
   input  logic [2:0]  csr_wdata
);
   import mlpc_pkg::*;

   cmd_type    cmd;
   status_type status;

   mlpc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   mlpc_datapath #(.ENTRY_COUNT(ENTRY_COUNT)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_address      (req_address),
      .req_data_byte    (req_data_byte),
      .req_bytes_left   (req_bytes_left),
      .req_entry_slot   (req_entry_slot),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_direct    (rsp_is_direct),
      .rsp_is_hit       (rsp_is_hit),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_fill_start   (rsp_fill_start),
      .rsp_fill_length  (rsp_fill_length),
      .rsp_segment_count(rsp_segment_count),
      .rsp_flushed      (rsp_flushed)
   );

endmodule
